/* rtl/uatd_pkg.sv */
// Shared constants and helpers for the unsigned-to-ASCII digit converter.
package uatd_pkg;

	localparam int VALUE_W     = 64;
	localparam int RADIX_W     = 6;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int RADIX_MIN   = 2;
	localparam int RADIX_MAX   = 36;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW    = 6;
	localparam int COUNT_W     = 7;
	localparam int DEC_DIGITS  = 10;
	localparam int CHAR_ZERO   = 48;
	localparam int CHAR_A      = 65;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_CW    = 2;

	// Map a digit value to its ASCII character: 0-9 then A upward.
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] d_ext;
		d_ext = {1'b0, d};
		if (d_ext < CHAR_W'(DEC_DIGITS)) begin
			return CHAR_W'(CHAR_ZERO) + d_ext;
		end else begin
			return CHAR_W'(CHAR_A - DEC_DIGITS) + d_ext;
		end
	endfunction

endpackage

/* rtl/uatd_if.sv */
// Channel interfaces: conversion request input and digit output.
interface uatd_in_if;
	import uatd_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [RADIX_W-1:0] radix;
	modport source(output valid, value, radix, input ready);
	modport sink(input valid, value, radix, output ready);
endinterface

interface uatd_out_if;
	import uatd_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] digit_char;
	logic              last_digit;
	modport source(output valid, digit_char, last_digit, input ready);
	modport sink(input valid, digit_char, last_digit, output ready);
endinterface

/* rtl/uatd_front.sv */
// Front end: accept a request, mask the value, clamp the radix, flag zero.
module uatd_front #(
	parameter int VALUE_BITS = 64,
	parameter int ITEM_W     = VALUE_BITS + 7
) (
	input  logic              clk,
	input  logic              arst_n,
	uatd_in_if.sink           items,
	output logic              push_valid,
	input  logic              push_ready,
	output logic [ITEM_W-1:0] push_data
);
	import uatd_pkg::*;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [RADIX_W-1:0]    radix_s1;
	logic                  zero_s1;
	logic [VALUE_BITS-1:0] value_m;
	logic [RADIX_W-1:0]    radix_c;

	assign value_m = items.value[VALUE_BITS-1:0];

	always_comb begin
		priority if (items.radix < RADIX_W'(RADIX_MIN)) begin
			radix_c = RADIX_W'(RADIX_MIN);
		end else if (items.radix > RADIX_W'(RADIX_MAX)) begin
			radix_c = RADIX_W'(RADIX_MAX);
		end else begin
			radix_c = items.radix;
		end
	end

	// Stage register frees when the queue takes its item.
	assign items.ready = !valid_s1 || push_ready;
	assign push_valid  = valid_s1;
	assign push_data   = {zero_s1, radix_s1, value_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			value_s1 <= '0;
			radix_s1 <= '0;
			zero_s1  <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
			if (items.valid) begin
				value_s1 <= value_m;
				radix_s1 <= radix_c;
				zero_s1  <= (value_m == '0);
			end
		end
	end

endmodule

/* rtl/uatd_fifo.sv */
// Two-entry queue between the front end and the divide engine.
module uatd_fifo #(
	parameter int DATA_W = 71
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	import uatd_pkg::*;

	logic [DATA_W-1:0]   mem [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign push_ready = (cnt_q != QUEUE_CW'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/uatd_back.sv */
// Divide engine: bit-serial divide per digit, digit store, reversed emission.
module uatd_back #(
	parameter int VALUE_BITS = 64,
	parameter int ITEM_W     = VALUE_BITS + 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [ITEM_W-1:0] pop_data,
	uatd_out_if.source        digits
);
	import uatd_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_EMIT_RD,
		S_EMIT_LD
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic [STORE_AW-1:0]   idx_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic [DIGIT_W-1:0]    store [STORE_DEPTH];
	logic [DIGIT_W-1:0]    rd_data_q;

	logic [VALUE_BITS-1:0] in_value;
	logic [RADIX_W-1:0]    in_radix;
	logic                  in_zero;
	logic [DIGIT_W:0]      rem_sh;
	logic [DIGIT_W:0]      rem_diff;
	logic                  ge;
	logic [DIGIT_W-1:0]    rem_nx;
	logic [VALUE_BITS-1:0] quo_nx;
	logic                  bit_last;
	logic                  wr_en;
	logic [STORE_AW-1:0]   wr_addr;
	logic [DIGIT_W-1:0]    wr_data;
	logic                  load;
	logic                  emit;

	assign {in_zero, in_radix, in_value} = pop_data;
	assign pop_ready = (state_q == S_IDLE);

	// One restoring-division step: shift in the next quotient bit.
	assign rem_sh   = {rem_q, quo_q[VALUE_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, radix_q};
	assign ge       = (rem_sh >= {1'b0, radix_q});
	assign rem_nx   = ge ? rem_diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
	assign quo_nx   = {quo_q[VALUE_BITS-2:0], ge};
	assign bit_last = (bit_cnt_q == CNT_W'(VALUE_BITS - 1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		if (state_q == S_DIV && bit_last) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[STORE_AW-1:0];
			wr_data = rem_nx;
		end else if (state_q == S_IDLE && pop_valid && in_zero) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		rd_data_q <= store[idx_q];
	end

	assign load = !out_valid_q || digits.ready;
	assign emit = (state_q == S_EMIT_LD) && load;

	assign digits.valid      = out_valid_q;
	assign digits.digit_char = char_q;
	assign digits.last_digit = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quo_q       <= '0;
			rem_q       <= '0;
			radix_q     <= '0;
			bit_cnt_q   <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (digits.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						quo_q     <= in_value;
						radix_q   <= in_radix;
						rem_q     <= '0;
						bit_cnt_q <= '0;
						idx_q     <= '0;
						if (in_zero) begin
							cnt_q   <= COUNT_W'(1);
							state_q <= S_EMIT_RD;
						end else begin
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= quo_nx;
					if (bit_last) begin
						rem_q     <= '0;
						bit_cnt_q <= '0;
						cnt_q     <= cnt_q + 1'b1;
						if (quo_nx == '0) begin
							idx_q   <= cnt_q[STORE_AW-1:0];
							state_q <= S_EMIT_RD;
						end
					end else begin
						rem_q     <= rem_nx;
						bit_cnt_q <= bit_cnt_q + 1'b1;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					if (load) begin
						char_q <= to_ascii(rd_data_q);
						last_q <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/unsigned_to_ascii_digits.sv */
// Top level of the unsigned binary to ASCII digit converter.
//
//   channel | dir | payload                          | transfer when
//   --------+-----+----------------------------------+--------------------
//   items   | in  | value[63:0], radix[5:0]          | valid && ready
//   digits  | out | digit_char[6:0], last_digit      | valid && ready
//
// A nonzero value of D digits takes D divides of VALUE_BITS bits each in the
// bit-serial divider (one quotient bit per cycle, one divide per digit), and
// each digit is then read from the digit store and loaded into the output
// register. A zero value skips the divider. Entry passes through the front
// stage register and then the queue.
// arst_n clears all control state at once; the digit store is not cleared.
// The front stage and queue keep taking requests while the divider works or
// the output stalls, until both are full; a stalled digit holds in the output register.
module unsigned_to_ascii_digits #(
	parameter int VALUE_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	uatd_in_if.sink    items,
	uatd_out_if.source digits
);
	import uatd_pkg::*;

	// Queue item: zero flag, clamped radix, masked value.
	localparam int ITEM_W = VALUE_BITS + RADIX_W + 1;

	logic              push_valid;
	logic              push_ready;
	logic [ITEM_W-1:0] push_data;
	logic              pop_valid;
	logic              pop_ready;
	logic [ITEM_W-1:0] pop_data;

	// Front: hold one classified request until the queue has room.
	uatd_front #(
		.VALUE_BITS(VALUE_BITS),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// Queue: decouple acceptance from the long divide.
	uatd_fifo #(
		.DATA_W(ITEM_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// Back: divide, store remainders, emit most significant digit first.
	uatd_back #(
		.VALUE_BITS(VALUE_BITS),
		.ITEM_W    (ITEM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.digits   (digits)
	);

endmodule

/* rtl/uatd_checker.sv */
// Port-level checks for the digit converter and their binding.
module uatd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] out_char,
	input logic       out_last
);
	// High while the next digit transfer opens a new run.
	logic run_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_start_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			run_start_q <= out_last;
		end
	end

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_char >= 7'd48 && out_char <= 7'd57) ||
		               (out_char >= 7'd65 && out_char <= 7'd90)))
		else $error("digit character outside 0-9 and A-Z");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("stalled digit changed or dropped");

	a_no_lead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_start_q && out_char == 7'd48 |-> out_last)
		else $error("leading zero digit in a multi-digit run");

endmodule

bind unsigned_to_ascii_digits uatd_checker u_uatd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(digits.valid),
	.out_ready(digits.ready),
	.out_char (digits.digit_char),
	.out_last (digits.last_digit)
);

/* tb/uatd_digit_checker.sv */
// Checker for the digit converter: predicts the digit run of each request and compares.
module uatd_digit_checker #(
	parameter int VALUE_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	uatd_in_if   items,
	uatd_out_if  digits,
	output int   fail_count,
	output int   digits_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import uatd_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} ascii_digit_t;

	ascii_digit_t expected_digits[$];

	task automatic flag_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic logic [CHAR_W-1:0] digit_glyph(input int unsigned d);
		if (d < DEC_DIGITS)
			return CHAR_W'(CHAR_ZERO + d);
		return CHAR_W'(CHAR_A + d - DEC_DIGITS);
	endfunction

	// Divide down to zero, then queue the remainders most significant first.
	function automatic void expand_to_digits(input logic [VALUE_W-1:0] value,
	                                         input logic [RADIX_W-1:0] radix);
		logic [VALUE_W-1:0] quotient;
		logic [VALUE_W-1:0] keep_mask;
		int unsigned        base;
		int unsigned        rems[STORE_DEPTH];
		int                 n;
		ascii_digit_t       item;
		base = radix;
		if (base < RADIX_MIN)
			base = RADIX_MIN;
		if (base > RADIX_MAX)
			base = RADIX_MAX;
		keep_mask = (VALUE_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << VALUE_BITS) - 1'b1);
		quotient = value & keep_mask;
		n = 0;
		if (quotient == '0) begin
			rems[0] = 0;
			n = 1;
		end
		while (quotient != '0 && n < STORE_DEPTH) begin
			rems[n] = int'(quotient % VALUE_W'(base));
			quotient = quotient / VALUE_W'(base);
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			item.code = digit_glyph(rems[k]);
			item.last = (k == 0);
			expected_digits.push_back(item);
		end
	endfunction

	always @(posedge clk) begin
		ascii_digit_t want;
		if (!arst_n) begin
			fail_count = 0;
			digits_pending <= 0;
			expected_digits.delete();
		end else begin
			if (digits.valid === 1'b1 && digits.ready === 1'b1) begin
				if (expected_digits.size() == 0) begin
					flag_mismatch($sformatf("unexpected digit char=%0d last=%b",
						digits.digit_char, digits.last_digit));
				end else begin
					want = expected_digits.pop_front();
					if (digits.digit_char !== want.code)
						flag_mismatch($sformatf("digit_char got %0d want %0d",
							digits.digit_char, want.code));
					if (digits.last_digit !== want.last)
						flag_mismatch($sformatf("last_digit got %b want %b",
							digits.last_digit, want.last));
				end
			end
			if (items.valid === 1'b1 && items.ready === 1'b1)
				expand_to_digits(items.value, items.radix);
			digits_pending <= expected_digits.size();
		end
	end

endmodule

/* tb/tb.sv */
// Top of the digit converter testbench: clock, reset, request stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import uatd_pkg::*;

	localparam int VALUE_BITS   = 64;
	localparam int RANDOM_ITEMS = 280;
	// A 64-digit binary run needs 64 full divides before its first digit can
	// leave; the limit on cycles with no transfer on either channel allows for that.
	localparam int IDLE_LIMIT   = 20000;
	localparam int TAIL_CYCLES  = 100;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   digits_pending;
	int   idle_cycles;

	uatd_in_if  items_ch ();
	uatd_out_if digits_ch ();

	unsigned_to_ascii_digits #(.VALUE_BITS(VALUE_BITS)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.items (items_ch),
		.digits(digits_ch)
	);

	uatd_digit_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.items         (items_ch),
		.digits        (digits_ch),
		.fail_count    (fail_count),
		.digits_pending(digits_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Digit sink backpressure: rotate an 8-bit ready mask and pick a fresh mask
	// now and then. The mask always holds at least one set bit, so a stall
	// always ends; the all-ones mask gives stall-free stretches.
	logic [7:0] ready_mask;
	int         mask_age;

	always @(posedge clk) begin
		if (!arst_n) begin
			digits_ch.ready <= 1'b0;
			ready_mask      <= 8'hFF;
			mask_age        <= 0;
		end else begin
			digits_ch.ready <= ready_mask[0];
			if (mask_age >= 97) begin
				mask_age <= 0;
				case ($urandom_range(0, 3))
					0: ready_mask <= 8'hFF;
					1: ready_mask <= 8'($urandom) | 8'h01;
					2: ready_mask <= 8'h01;
					default: ready_mask <= 8'hAA;
				endcase
			end else begin
				mask_age   <= mask_age + 1;
				ready_mask <= {ready_mask[0], ready_mask[7:1]};
			end
		end
	end

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((items_ch.valid && items_ch.ready) || (digits_ch.valid && digits_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[unsigned_to_ascii_digits] ERROR");
				$finish;
			end
		end
	end

	// Present one request and hold it until the block takes it. Valid stays
	// high on return so that a back-to-back request needs no extra edge.
	task automatic offer_request(input logic [VALUE_W-1:0] value,
	                             input logic [RADIX_W-1:0] radix);
		items_ch.valid <= 1'b1;
		items_ch.value <= value;
		items_ch.radix <= radix;
		do
			@(posedge clk);
		while (items_ch.ready !== 1'b1);
	endtask

	// Drop valid and idle for a number of cycles.
	task automatic pause_sender(input int cycles);
		items_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random request: mostly short values so that runs stay cheap, a tenth at
	// full width, a few zeros; radix mostly legal, sometimes any 6-bit code so
	// that both clamps get hit.
	task automatic offer_random_request();
		logic [VALUE_W-1:0] raw;
		int                 width;
		int unsigned        pick;
		logic [RADIX_W-1:0] radix;
		raw  = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 5)
			width = 0;
		else if (pick < 65)
			width = $urandom_range(1, 24);
		else if (pick < 90)
			width = $urandom_range(25, 63);
		else
			width = VALUE_W;
		if (width == 0)
			raw = '0;
		else
			raw = raw >> (VALUE_W - width);
		if ($urandom_range(0, 99) < 85)
			radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
		else
			radix = RADIX_W'($urandom_range(0, 63));
		offer_request(raw, radix);
	endtask

	initial begin
		int burst_left;
		arst_n          = 1'b0;
		items_ch.valid  = 1'b0;
		items_ch.value  = '0;
		items_ch.radix  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, sent back to back: zero in several bases, the
		// largest value in the extreme and common bases, the top digit 'Z',
		// digit boundaries around nine and ten, and radix codes below two
		// and above thirty-six.
		offer_request('0, 6'd10);
		offer_request('0, 6'd2);
		offer_request('0, 6'd36);
		offer_request('1, 6'd2);
		offer_request('1, 6'd10);
		offer_request('1, 6'd16);
		offer_request('1, 6'd36);
		offer_request(64'd1, 6'd2);
		offer_request(64'd35, 6'd36);
		offer_request(64'd36, 6'd36);
		offer_request(64'd9, 6'd10);
		offer_request(64'd10, 6'd10);
		offer_request(64'd10, 6'd16);
		offer_request(64'd255, 6'd0);
		offer_request(64'd255, 6'd1);
		offer_request(64'd1295, 6'd37);
		offer_request(64'd1295, 6'd63);
		offer_request(64'h8000_0000_0000_0000, 6'd8);
		offer_request(64'd123456789, 6'd10);
		offer_request(64'hFEDC_BA98_7654_3210, 6'd16);
		offer_request(64'd5, 6'd3);
		pause_sender(3);

		// Random part in bursts; some bursts are followed by no gap at all.
		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			offer_random_request();
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 12);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 30));
			end
		end
		items_ch.valid <= 1'b0;
		// Let the pending count take in the last request before reading it.
		@(posedge clk);

		// Drain: wait for every predicted digit, then watch for strays.
		while (digits_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[unsigned_to_ascii_digits] OK");
		else
			$display("[unsigned_to_ascii_digits] ERROR");
		$finish;
	end

endmodule
